FILE: rtl/angled_slit_scan_frame_select_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angled slit-scan frame select unit
// Short forms of the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ANGLED_SLIT_SCAN_FRAME_SELECT_UNIT_MACROS_SVH
`define ANGLED_SLIT_SCAN_FRAME_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asfs check failed");

// Next-cycle implication, held off while reset is asserted.
`define ASFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asfs check failed");

`endif

FILE: rtl/asfs_pkg.sv
// ----------------------------------------------------------------------------
// asfs_pkg
// Types, constants and helpers shared by the frame select unit.
// ----------------------------------------------------------------------------
package asfs_pkg;

    localparam int DIV_W     = 34;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int T_W       = 17;
    localparam int PM_W      = 18;
    localparam int PIX_W     = 32;
    localparam int AGE_OUT_W = 4;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_DIR_COS       = 3'd3,
        REG_DIR_SIN       = 3'd4,
        REG_EASE_CURVE    = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PIDX, ST_WRITE, ST_DIVX, ST_DIVY, ST_MULX, ST_MULY, ST_SUM,
        ST_TSTART, ST_DIVT, ST_EASE1, ST_EASE2, ST_EASE3, ST_AGE1, ST_AGE2,
        ST_RADDR, ST_READ, ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    // Keep only the configured number of 8-bit channels.
    function automatic logic [PIX_W-1:0] chan_mask(input logic [2:0] cc);
        logic [PIX_W-1:0] m;
        unique case (cc)
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/asfs_div.sv
// ----------------------------------------------------------------------------
// asfs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asfs_div
    import asfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] den_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

FILE: rtl/angled_slit_scan_frame_select_unit.sv
// ----------------------------------------------------------------------------
// angled_slit_scan_frame_select_unit
// Slit-scan time displacement along a configurable scan direction.
// ----------------------------------------------------------------------------
// Each incoming pixel is written into a ring of FRAME_SLOTS frame slots held in
// one synchronous memory, and the pixel at the same position from an older
// frame is returned; how far back depends on where the pixel lies along the
// direction (dir_cos, dir_sin). The unit works on one pixel at a time. A pixel
// that finds fewer than two frames held passes through ST_PIDX and ST_WRITE and
// is then loaded from ST_OUT into the output register. Otherwise the shared
// bit-serial divider sets the pace: it runs three times per pixel (x coordinate,
// y coordinate, scan position), and easing adds ST_EASE2 and ST_EASE3; when both
// direction registers are zero the divider is skipped. The next pixel can
// be taken in the cycle after the result is loaded into the output register.
// A new pixel is taken while the previous result still waits in the output
// register. The frame memory needs no clearing pass;
// a position of a held frame never written is not read by a well-formed stream.
// Configuration writes are taken at any clock; a write that changes the size or
// channel count empties the history unless a pixel is accepted in that clock.
// ----------------------------------------------------------------------------
module angled_slit_scan_frame_select_unit
    import asfs_pkg::*;
#(
    parameter int FRAME_SLOTS = 16,
    parameter int MAX_WIDTH   = 512,
    parameter int MAX_HEIGHT  = 512
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel_in,
    input  logic                 first_of_frame,
    input  logic                 clear_history,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     pixel_out,
    output logic [AGE_OUT_W-1:0] frame_age
);

    localparam int FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH       = FRAME_SLOTS * FRAME_WORDS;
    localparam int AW          = $clog2(DEPTH);
    localparam int SW          = $clog2(FRAME_SLOTS);
    localparam int HW          = $clog2(FRAME_SLOTS + 1);
    localparam int PROD_W      = T_W + SW;

    // Configuration registers.
    logic [9:0]        frame_width_reg;
    logic [9:0]        frame_height_reg;
    logic [2:0]        channel_count_reg;
    logic signed [15:0] dir_cos_reg;
    logic signed [15:0] dir_sin_reg;
    logic              ease_curve_reg;

    // History and raster position.
    logic [SW-1:0]     write_slot_reg;
    logic [HW-1:0]     frames_held_reg;
    logic [POS_W-1:0]  column_pos_reg;
    logic [POS_W-1:0]  row_pos_reg;

    state_t            state_reg;
    state_t            state_next;

    // Per-transaction working registers.
    logic [PIX_W-1:0]  pix_reg;
    logic [POS_W-1:0]  cur_col_reg;
    logic [POS_W-1:0]  cur_row_reg;
    logic [SW-1:0]     cur_slot_reg;
    logic [HW-1:0]     held_cur_reg;
    logic [SW-1:0]     maxt_reg;
    logic [AW-1:0]     pidx_reg;
    logic [AW-1:0]     waddr_reg;
    logic [AW-1:0]     raddr_reg;
    logic signed [17:0] xn_reg;
    logic signed [17:0] yn_reg;
    logic signed [33:0] px_reg;
    logic signed [33:0] py_reg;
    logic [DIV_W-1:0]  sum_reg;
    logic [T_W-1:0]    t_reg;
    logic [2*T_W-1:0]  sq_reg;
    logic [50:0]       e_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SW-1:0]     age_reg;
    logic              use_mem_reg;

    logic [PIX_W-1:0]  out_pix_reg;
    logic [AGE_OUT_W-1:0] out_age_reg;
    logic              out_valid_reg;

    // Frame memory.
    logic [PIX_W-1:0]  mem [DEPTH];
    logic [PIX_W-1:0]  mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Effective sizes and direction magnitude.
    logic [9:0]        w_eff;
    logic [9:0]        h_eff;
    logic [10:0]       dx;
    logic [10:0]       dy;
    logic [PIX_W-1:0]  mask;
    logic signed [16:0] cos_x;
    logic signed [16:0] sin_x;
    logic [16:0]       cos_abs;
    logic [16:0]       sin_abs;
    logic [PM_W-1:0]   pm;

    logic              accept;
    logic              size_change;
    logic              out_load;

    // Stepping of the history at acceptance.
    logic [HW-1:0]     held_a;
    logic [SW-1:0]     slot_a;
    logic [POS_W-1:0]  col_a;
    logic [POS_W-1:0]  row_a;
    logic [POS_W-1:0]  col_b;
    logic [POS_W-1:0]  row_b;
    logic [POS_W-1:0]  col_n;
    logic [POS_W-1:0]  row_n;

    logic signed [35:0] sum_full;
    logic signed [18:0] q_coord;
    logic [17:0]        ease_k;
    logic [PROD_W-1:0]  age_raw;
    logic [SW-1:0]      rslot;

    always_comb
    begin
        if (frame_width_reg == 10'd0)
            w_eff = 10'd1;
        else if (int'(frame_width_reg) > MAX_WIDTH)
            w_eff = 10'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;
        if (frame_height_reg == 10'd0)
            h_eff = 10'd1;
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            h_eff = 10'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    assign dx      = (w_eff > 10'd1) ? 11'(w_eff - 10'd1) : 11'd1;
    assign dy      = (h_eff > 10'd1) ? 11'(h_eff - 10'd1) : 11'd1;
    assign mask    = chan_mask(channel_count_reg);
    assign cos_x   = 17'(dir_cos_reg);
    assign sin_x   = 17'(dir_sin_reg);
    assign cos_abs = cos_x[16] ? 17'(-cos_x) : 17'(cos_x);
    assign sin_abs = sin_x[16] ? 17'(-sin_x) : 17'(sin_x);
    assign pm      = PM_W'(cos_abs) + PM_W'(sin_abs);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        size_change = 1'b0;
        if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   size_change = cfg_data[9:0] != frame_width_reg;
                REG_FRAME_HEIGHT:  size_change = cfg_data[9:0] != frame_height_reg;
                REG_CHANNEL_COUNT: size_change = cfg_data[2:0] != channel_count_reg;
                default:           size_change = 1'b0;
            endcase
        end
    end

    // A transaction first applies a clear, then a frame start (also taken when no frame
    // is held), then wraps an overrun position; the wrapped position is the pixel's own.
    always_comb
    begin
        held_a = clear_history ? '0 : frames_held_reg;
        slot_a = clear_history ? '0 : write_slot_reg;
        col_a  = clear_history ? '0 : column_pos_reg;
        row_a  = clear_history ? '0 : row_pos_reg;
        if (first_of_frame || held_a == '0)
        begin
            if (held_a != '0)
                slot_a = (int'(slot_a) == FRAME_SLOTS - 1) ? '0 : slot_a + 1'b1;
            if (int'(held_a) < FRAME_SLOTS)
                held_a = held_a + 1'b1;
            col_a = '0;
            row_a = '0;
        end
        col_b = col_a;
        row_b = row_a;
        if (col_a >= w_eff || row_a >= h_eff)
        begin
            col_b = '0;
            row_b = '0;
        end
        col_n = col_b + 1'b1;
        row_n = row_b;
        if (col_n >= w_eff)
        begin
            col_n = '0;
            row_n = row_b + 1'b1;
            if (row_n >= h_eff)
                row_n = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= 10'd512;
            frame_height_reg  <= 10'd512;
            channel_count_reg <= 3'd3;
            dir_cos_reg       <= 16'sd16384;
            dir_sin_reg       <= 16'sd0;
            ease_curve_reg    <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[9:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[9:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[2:0];
                REG_DIR_COS:       dir_cos_reg       <= cfg_data;
                REG_DIR_SIN:       dir_sin_reg       <= cfg_data;
                REG_EASE_CURVE:    ease_curve_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            frames_held_reg <= '0;
            column_pos_reg  <= '0;
            row_pos_reg     <= '0;
        end
        else if (accept)
        begin
            write_slot_reg  <= slot_a;
            frames_held_reg <= held_a;
            column_pos_reg  <= col_n;
            row_pos_reg     <= row_n;
        end
        else if (size_change)
        begin
            write_slot_reg  <= '0;
            frames_held_reg <= '0;
            column_pos_reg  <= '0;
            row_pos_reg     <= '0;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next  = state_reg;
        div_req     = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        sum_full    = 36'(px_reg) + 36'(py_reg) + $signed({2'b00, pm, 16'h0000});
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_PIDX;
            ST_PIDX:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (held_cur_reg < HW'(2))
                    state_next = ST_OUT;
                else if (pm == '0)
                    state_next = ST_EASE1;
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'({cur_col_reg, 18'h00000}) + DIV_W'(dx);
                    div_req.den   = DIV_W'({dx, 1'b0});
                    state_next    = ST_DIVX;
                end
            end
            ST_DIVX:
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'({cur_row_reg, 18'h00000}) + DIV_W'(dy);
                    div_req.den   = DIV_W'({dy, 1'b0});
                    state_next    = ST_DIVY;
                end
            ST_DIVY:
                if (div_rsp.done)
                    state_next = ST_MULX;
            ST_MULX:
                state_next = ST_MULY;
            ST_MULY:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_TSTART;
            ST_TSTART:
            begin
                div_req.start = 1'b1;
                div_req.num   = sum_reg + DIV_W'(pm);
                div_req.den   = DIV_W'({pm, 1'b0});
                state_next    = ST_DIVT;
            end
            ST_DIVT:
                if (div_rsp.done)
                    state_next = ST_EASE1;
            ST_EASE1:
                state_next = ease_curve_reg ? ST_EASE2 : ST_AGE1;
            ST_EASE2:
                state_next = ST_EASE3;
            ST_EASE3:
                state_next = ST_AGE1;
            ST_AGE1:
                state_next = ST_AGE2;
            ST_AGE2:
                state_next = ST_RADDR;
            ST_RADDR:
                state_next = ST_READ;
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    asfs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q_coord = $signed({1'b0, div_rsp.quot[17:0]}) - 19'sd65536;
    assign ease_k  = 18'd196608 - {t_reg, 1'b0};
    assign age_raw = prod_reg + PROD_W'(32768);
    assign rslot   = (age_reg > cur_slot_reg)
                   ? SW'(int'(cur_slot_reg) + FRAME_SLOTS - int'(age_reg))
                   : cur_slot_reg - age_reg;

    // Datapath registers, advanced by the sequencer.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    pix_reg      <= pixel_in & mask;
                    cur_col_reg  <= col_b;
                    cur_row_reg  <= row_b;
                    cur_slot_reg <= slot_a;
                    held_cur_reg <= held_a;
                    maxt_reg     <= SW'(held_a - 1'b1);
                end
            ST_PIDX:
            begin
                pidx_reg  <= AW'(cur_row_reg) * AW'(MAX_WIDTH) + AW'(cur_col_reg);
                waddr_reg <= AW'(cur_slot_reg) * AW'(FRAME_WORDS)
                           + AW'(cur_row_reg) * AW'(MAX_WIDTH) + AW'(cur_col_reg);
            end
            ST_WRITE:
            begin
                t_reg       <= '0;
                age_reg     <= '0;
                use_mem_reg <= held_cur_reg >= HW'(2);
            end
            ST_DIVX:
                if (div_rsp.done)
                    xn_reg <= q_coord[17:0];
            ST_DIVY:
                if (div_rsp.done)
                    yn_reg <= q_coord[17:0];
            ST_MULX:
                px_reg <= xn_reg * dir_cos_reg;
            ST_MULY:
                py_reg <= yn_reg * dir_sin_reg;
            ST_SUM:
                sum_reg <= sum_full[35] ? '0 : sum_full[DIV_W-1:0];
            ST_DIVT:
                if (div_rsp.done)
                    t_reg <= (div_rsp.quot > DIV_W'(T_ONE)) ? T_ONE : div_rsp.quot[T_W-1:0];
            ST_EASE1:
                sq_reg <= t_reg * t_reg;
            ST_EASE2:
                e_reg <= 51'(sq_reg) * 51'(ease_k);
            ST_EASE3:
                t_reg <= T_W'((52'(e_reg) + 52'h8000_0000) >> 32);
            ST_AGE1:
                prod_reg <= PROD_W'(t_reg) * PROD_W'(maxt_reg);
            ST_AGE2:
                age_reg <= (age_raw[PROD_W-1:16] > PROD_W'(maxt_reg))
                         ? maxt_reg : SW'(age_raw[PROD_W-1:16]);
            ST_RADDR:
                raddr_reg <= AW'(rslot) * AW'(FRAME_WORDS) + pidx_reg;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr_reg] <= pix_reg;
        if (mem_re)
            mem_rdata_reg <= mem[raddr_reg];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pix_reg <= use_mem_reg ? (mem_rdata_reg & mask) : pix_reg;
            out_age_reg <= AGE_OUT_W'(age_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = out_pix_reg;
    assign frame_age = out_age_reg;

endmodule

FILE: rtl/asfs_checker.sv
// ----------------------------------------------------------------------------
// asfs_checker
// Port-level checks for the angled slit-scan frame select unit.
// ----------------------------------------------------------------------------
`include "angled_slit_scan_frame_select_unit_macros.svh"

module asfs_checker
    import asfs_pkg::*;
#(
    parameter int FRAME_SLOTS = 16
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [AGE_OUT_W-1:0] frame_age
);

    // One pixel at a time: the unit is busy right after taking a transaction.
    `ASFS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // A result cannot show up in the cycle right after an input transaction.
    `ASFS_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

    // A stalled result stays offered.
    `ASFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // The age never reaches past the ring; checked only when the ring has fewer than 16 slots.
    `ASFS_ASSERT_IMPL(a_age_range, clk, rst_n, out_valid, (FRAME_SLOTS >= 16) || (frame_age < FRAME_SLOTS))

endmodule

bind angled_slit_scan_frame_select_unit asfs_checker #(.FRAME_SLOTS(FRAME_SLOTS)) u_asfs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame_age (frame_age)
);
